### hw/rtl/rhms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range hysteresis mode switch package
// Shared payload types, register indexes and fixed constants of the block.
// ----------------------------------------------------------------------------
package rhms_pkg;

    localparam int DIST_W = 16;
    localparam int RATE_W = 9;
    localparam int AVG_W  = 24;
    localparam int FRAC_W = 8;
    localparam int CNT_W  = 16;
    localparam int ADDR_W = 2;
    localparam int DATA_W = 16;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_SHORT_THRESHOLD = 2'd0;
    localparam logic [ADDR_W-1:0] REG_LONG_THRESHOLD  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_SMOOTHING_RATE  = 2'd2;
    localparam logic [ADDR_W-1:0] REG_HOLD_OFF_FRAMES = 2'd3;

    // Register reset values.
    localparam logic [DIST_W-1:0] SHORT_THRESHOLD_RST = 16'd1000;
    localparam logic [DIST_W-1:0] LONG_THRESHOLD_RST  = 16'd3000;
    localparam logic [RATE_W-1:0] SMOOTHING_RATE_RST  = 9'd64;
    localparam logic [CNT_W-1:0]  HOLD_OFF_FRAMES_RST = 16'd300;

    // Full weight of the new sample (1.0 in units of 1/256).
    localparam logic [RATE_W-1:0] RATE_ONE = 9'd256;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 16'hFFFF;

    // A lost count is a multiple of 200 when its low three bits are zero
    // and the remaining 13 bits are a multiple of 25. The latter is tested
    // by multiplying with the inverse of 25 modulo 2^13: multiples of 25
    // map onto 0 .. floor((2^13 - 1) / 25).
    localparam int LOST_SHIFT = 3;
    localparam int LOST_HI_W  = 13;
    localparam logic [LOST_HI_W-1:0] LOST_INV25 = 13'd7209;
    localparam logic [LOST_HI_W-1:0] LOST_LIMIT = 13'd327;

    localparam logic MODE_NEAR = 1'b0;
    localparam logic MODE_FAR  = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [CNT_W-1:0]  lost_count;
        logic              current_mode;
    } t_in_item;

    typedef struct packed {
        logic              next_mode;
        logic [DIST_W-1:0] smoothed_distance;
    } t_out_item;

    // Threshold status of the updated average.
    typedef struct packed {
        logic above_long;
        logic below_short;
    } t_avg_flags;

endpackage

### hw/rtl/range_hysteresis_mode_switch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range hysteresis mode switch
// Chooses near or far ranging mode per frame from a smoothed distance.
// ----------------------------------------------------------------------------
// One input transaction per frame carries the measured distance (0 when no
// target is seen), the count of consecutive lost frames and the mode in use;
// one output transaction returns the mode for the next frame and the integer
// part of the Q16.8 distance average. Each transaction is held in an input
// register and processed in the single cycle it moves into the output
// register, so the block takes one transaction per clock unless the output
// side stalls; the throughput is set by the average update, one 10 x 25 bit
// multiply-add with its threshold compares, and by the mode decision that
// follows it in the same cycle. The average and the frame counter are
// updated at that same edge, so back-to-back frames see each other's state.
// Configuration writes take effect at the next clock edge and should only be
// issued while no transaction is in flight.
module range_hysteresis_mode_switch (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rhms_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [rhms_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rhms_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rhms_pkg::t_out_item           o_out_data
);

    // Configuration registers.
    logic [rhms_pkg::DIST_W-1:0] r_short_threshold;
    logic [rhms_pkg::DIST_W-1:0] r_long_threshold;
    logic [rhms_pkg::RATE_W-1:0] r_smoothing_rate;
    logic [rhms_pkg::CNT_W-1:0]  r_hold_off_frames;

    // Pipeline registers.
    logic                 r_in_valid;
    rhms_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    rhms_pkg::t_out_item  r_out;

    // Frame state.
    logic [rhms_pkg::AVG_W-1:0] r_avg;
    logic [rhms_pkg::CNT_W-1:0] r_frames;

    logic                       w_advance;
    logic [rhms_pkg::AVG_W-1:0] n_avg;
    rhms_pkg::t_avg_flags       w_flags;
    logic [2*rhms_pkg::LOST_HI_W-1:0] w_lost_prod;
    logic                       w_lost_toggle;
    logic                       w_proposal;
    logic [rhms_pkg::CNT_W-1:0] w_frames_inc;
    logic                       w_change;
    logic [rhms_pkg::CNT_W-1:0] n_frames;
    rhms_pkg::t_out_item        n_out;

    // The stage moves when it holds a transaction and the output register
    // is empty or being drained this cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_threshold <= rhms_pkg::SHORT_THRESHOLD_RST;
            r_long_threshold  <= rhms_pkg::LONG_THRESHOLD_RST;
            r_smoothing_rate  <= rhms_pkg::SMOOTHING_RATE_RST;
            r_hold_off_frames <= rhms_pkg::HOLD_OFF_FRAMES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rhms_pkg::REG_SHORT_THRESHOLD: begin
                    r_short_threshold <= i_cfg_data;
                end
                rhms_pkg::REG_LONG_THRESHOLD: begin
                    r_long_threshold <= i_cfg_data;
                end
                rhms_pkg::REG_SMOOTHING_RATE: begin
                    r_smoothing_rate <= i_cfg_data[rhms_pkg::RATE_W-1:0];
                end
                rhms_pkg::REG_HOLD_OFF_FRAMES: begin
                    r_hold_off_frames <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    rhms_avg u_avg (
        .i_avg             (r_avg),
        .i_distance        (r_in.distance),
        .i_rate            (r_smoothing_rate),
        .i_short_threshold (r_short_threshold),
        .i_long_threshold  (r_long_threshold),
        .o_avg             (n_avg),
        .o_flags           (w_flags)
    );

    // Without a target, a toggle is proposed on every nonzero multiple of
    // 200 lost frames.
    assign w_lost_prod = r_in.lost_count[rhms_pkg::CNT_W-1:rhms_pkg::LOST_SHIFT]
                         * rhms_pkg::LOST_INV25;
    assign w_lost_toggle = (r_in.lost_count != '0)
                        && (r_in.lost_count[rhms_pkg::LOST_SHIFT-1:0] == '0)
                        && (w_lost_prod[rhms_pkg::LOST_HI_W-1:0] <= rhms_pkg::LOST_LIMIT);

    always_comb begin
        // Proposal: hysteresis on the average with a target, periodic toggle
        // without one.
        w_proposal = r_in.current_mode;
        if (r_in.distance == '0) begin
            if (w_lost_toggle) begin
                w_proposal = !r_in.current_mode;
            end
        end else if (w_flags.above_long && (r_in.current_mode == rhms_pkg::MODE_NEAR)) begin
            w_proposal = rhms_pkg::MODE_FAR;
        end else if (w_flags.below_short && (r_in.current_mode == rhms_pkg::MODE_FAR)) begin
            w_proposal = rhms_pkg::MODE_NEAR;
        end

        // The counter saturates; a change is let through only once it has
        // passed the hold-off, and then it restarts from zero.
        w_frames_inc = (r_frames == rhms_pkg::COUNT_MAX) ? r_frames
                                                         : r_frames + 1'b1;
        w_change = (w_proposal != r_in.current_mode)
                && (w_frames_inc > r_hold_off_frames);
        n_frames = w_change ? '0 : w_frames_inc;

        n_out.next_mode = w_change ? w_proposal : r_in.current_mode;
        n_out.smoothed_distance =
            n_avg[rhms_pkg::AVG_W-1:rhms_pkg::FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_avg       <= '0;
            r_frames    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_avg       <= n_avg;
                r_frames    <= n_frames;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // A frame without a target reports a cleared average.
    a_no_target_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in.distance == '0))
        |=> (r_avg == '0) && (o_out_data.smoothed_distance == '0))
        else $error("average not cleared on a frame without target");

    // Every mode change restarts the frame counter.
    a_change_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (n_out.next_mode != r_in.current_mode)) |=> (r_frames == '0))
        else $error("mode changed without restarting the frame counter");

    // A mode change needs a counter that already reached the hold-off.
    a_change_after_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (n_out.next_mode != r_in.current_mode))
        |-> (r_frames >= r_hold_off_frames))
        else $error("mode changed inside the hold-off");

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

endmodule

### hw/rtl/rhms_avg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range hysteresis average update
// Clears, seeds or blends the Q16.8 distance average and compares it to thresholds.
// ----------------------------------------------------------------------------
module rhms_avg (
    input  logic [rhms_pkg::AVG_W-1:0]  i_avg,
    input  logic [rhms_pkg::DIST_W-1:0] i_distance,
    input  logic [rhms_pkg::RATE_W-1:0] i_rate,
    input  logic [rhms_pkg::DIST_W-1:0] i_short_threshold,
    input  logic [rhms_pkg::DIST_W-1:0] i_long_threshold,
    output logic [rhms_pkg::AVG_W-1:0]  o_avg,
    output rhms_pkg::t_avg_flags        o_flags
);

    logic [rhms_pkg::RATE_W-1:0] w_rate;
    logic [rhms_pkg::AVG_W-1:0]  w_sample;
    logic signed [rhms_pkg::AVG_W:0] w_diff;
    logic signed [rhms_pkg::RATE_W+rhms_pkg::AVG_W+1:0] w_prod;
    logic signed [rhms_pkg::RATE_W+rhms_pkg::AVG_W+1:0] w_acc;
    logic [rhms_pkg::AVG_W-1:0]  w_blend;

    // Weights above one are taken as one.
    assign w_rate = (i_rate > rhms_pkg::RATE_ONE) ? rhms_pkg::RATE_ONE : i_rate;
    assign w_sample = {i_distance, {rhms_pkg::FRAC_W{1'b0}}};

    // (256 - r) * avg + r * s equals 256 * avg + r * (s - avg), which needs
    // a single multiplier. The sum is a convex blend and never negative.
    assign w_diff = $signed({1'b0, w_sample}) - $signed({1'b0, i_avg});
    assign w_prod = $signed({1'b0, w_rate}) * w_diff;
    assign w_acc  = $signed({3'b000, i_avg, {rhms_pkg::FRAC_W{1'b0}}}) + w_prod;
    assign w_blend = w_acc[rhms_pkg::AVG_W+rhms_pkg::FRAC_W-1:rhms_pkg::FRAC_W];

    always_comb begin
        if (i_distance == '0) begin
            o_avg = '0;
        end else if (i_avg == '0) begin
            o_avg = w_sample;
        end else begin
            o_avg = w_blend;
        end
        o_flags.above_long  = (o_avg > {i_long_threshold, {rhms_pkg::FRAC_W{1'b0}}});
        o_flags.below_short = (o_avg < {i_short_threshold, {rhms_pkg::FRAC_W{1'b0}}});
    end

endmodule
